/* hw/rtl/bcd_clock_with_keypad_set_top_defines.svh */
// Assertion macros for the BCD clock block.
// Taken in by `include in the checker file; no other dependencies.
`ifndef BCD_CLOCK_WITH_KEYPAD_SET_TOP_DEFINES_SVH
`define BCD_CLOCK_WITH_KEYPAD_SET_TOP_DEFINES_SVH

// Checked only out of reset.
`define BCDC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bcdclk assertion failed");

// Checked at every edge, reset included.
`define BCDC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bcdclk assertion failed");

`endif

/* hw/rtl/bcdclk_pkg.sv */
// Types and constants for the BCD clock with keypad set mode.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package bcdclk_pkg;

  localparam int unsigned NumDigits = 6;

  typedef logic [3:0] digit_t;
  typedef logic [2:0] pos_t;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_TOGGLE  = 3'd1,
    CMD_NEXT    = 3'd2,
    CMD_ENTER   = 3'd3,
    CMD_CONFIRM = 3'd4,
    CMD_CANCEL  = 3'd5
  } cmd_e;

  // digit limits
  localparam digit_t DecLimit       = 4'd10; // units wrap
  localparam digit_t SexLimit       = 4'd6;  // minute / second tens wrap
  localparam digit_t HourTensLimit  = 4'd3;  // confirm clamp on hour tens
  localparam digit_t HourTensTop    = 4'd2;  // tens at which hours wrap
  localparam digit_t HourUnitsLimit = 4'd4;  // units limit under tens of two
  localparam digit_t DigitMax       = 4'd9;

  localparam pos_t LastPos = 3'd5;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

endpackage

/* hw/rtl/bcd_clock_with_keypad_set_top.sv */
// BCD 24-hour clock with keypad set mode: top level.
// Depends on bcdclk_pkg.
//
//  channel  | dir | tdata fields (lsb up)                                 | width
//  ---------+-----+-------------------------------------------------------+------
//  s_axis   | in  | command[2:0], digit_value[6:3], zero pad [7]          | 8
//  m_axis   | out | hour_tens, hour_units, minute_tens, minute_units,     | 32
//           |     | second_tens, second_units, running, selected_position,|
//           |     | edit_value                                            |
//
// One word in, one word out; a word is taken every cycle while m_axis does not stall.
// The clock state updates at the edge that accepts the word, and the result
// lands in the output register at the same edge.
// The single output register sets the rate: s_axis_tready_o is high while it
// is empty or being drained, so a stalled m_axis holds the input back.
// Reset (rst_ni low, asynchronous) gives 00:00:00, run mode, digit 0.
`timescale 1ns / 1ps

module bcd_clock_with_keypad_set_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // command[2:0], digit_value[6:3], pad[7]
  input  logic [bcdclk_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // hour_tens[3:0], hour_units[7:4], minute_tens[11:8], minute_units[15:12],
  // second_tens[19:16], second_units[23:20], running[24],
  // selected_position[27:25], edit_value[31:28]
  output logic [bcdclk_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import bcdclk_pkg::*;

  // state
  digit_t time_q [NumDigits];
  digit_t time_d [NumDigits];
  digit_t edit_q [NumDigits];
  digit_t edit_d [NumDigits];
  logic   run_q, run_d;
  pos_t   pos_q, pos_d;

  // output register
  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic   accept;
  logic   [2:0] cmd;
  digit_t dval;
  pos_t   pidx_q, pidx_d;

  digit_t tick   [NumDigits];
  digit_t conf   [NumDigits];
  digit_t inc    [NumDigits];
  logic   carry5, carry4, carry3, carry2;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd             = s_axis_tdata_i[2:0];
  assign dval            = s_axis_tdata_i[6:3];

  // position out of range reads as digit 0
  assign pidx_q = (pos_q <= LastPos) ? pos_q : '0;
  assign pidx_d = (pos_d <= LastPos) ? pos_d : '0;

  // one-second advance with BCD carries, hours wrap 23 -> 00
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      inc[i]  = time_q[i] + 4'd1;
      tick[i] = time_q[i];
    end
    carry5 = (inc[5] >= DecLimit);
    carry4 = carry5 && (inc[4] >= SexLimit);
    carry3 = carry4 && (inc[3] >= DecLimit);
    carry2 = carry3 && (inc[2] >= SexLimit);

    tick[5] = carry5 ? '0 : inc[5];
    if (carry5) tick[4] = carry4 ? '0 : inc[4];
    if (carry4) tick[3] = carry3 ? '0 : inc[3];
    if (carry3) tick[2] = carry2 ? '0 : inc[2];
    if (carry2) begin
      if (time_q[0] < HourTensTop && inc[1] >= DecLimit) begin
        tick[0] = inc[0];
        tick[1] = '0;
      end else if (time_q[0] == HourTensTop && inc[1] >= HourUnitsLimit) begin
        tick[0] = '0;
        tick[1] = '0;
      end else begin
        tick[1] = inc[1];
      end
    end
  end

  // confirm: clamp out-of-range digits to zero
  always_comb begin
    conf[0] = (edit_q[0] >= HourTensLimit) ? '0 : edit_q[0];
    conf[1] = (edit_q[0] == HourTensTop && edit_q[1] >= HourUnitsLimit) ? '0 : edit_q[1];
    conf[2] = (edit_q[2] >= SexLimit) ? '0 : edit_q[2];
    conf[3] = edit_q[3];
    conf[4] = (edit_q[4] >= SexLimit) ? '0 : edit_q[4];
    conf[5] = edit_q[5];
  end

  // event decode
  always_comb begin
    time_d = time_q;
    edit_d = edit_q;
    run_d  = run_q;
    pos_d  = pos_q;
    if (accept) begin
      case (cmd)
        CMD_TICK: begin
          if (run_q) time_d = tick;
        end
        CMD_TOGGLE: begin
          run_d  = !run_q;
          edit_d = time_q;
        end
        CMD_NEXT: begin
          if (!run_q) pos_d = (pidx_q == LastPos) ? '0 : pidx_q + 3'd1;
        end
        CMD_ENTER: begin
          if (!run_q && dval <= DigitMax) edit_d[pidx_q] = dval;
        end
        CMD_CONFIRM: begin
          if (!run_q) begin
            time_d = conf;
            run_d  = 1'b1;
          end
        end
        CMD_CANCEL: begin
          if (!run_q) run_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result word from the state after the event
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    if (accept) begin
      m_valid_d = 1'b1;
      m_data_d  = {edit_d[pidx_d], pos_d, run_d,
                   time_d[5], time_d[4], time_d[3], time_d[2], time_d[1], time_d[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) begin
        time_q[i] <= '0;
        edit_q[i] <= '0;
      end
      run_q     <= 1'b1;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      time_q    <= time_d;
      edit_q    <= edit_d;
      run_q     <= run_d;
      pos_q     <= pos_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

/* hw/rtl/bcdclk_checker.sv */
// Port-level checker for the BCD clock top level, bound in below.
// Depends on bcdclk_pkg and bcd_clock_with_keypad_set_top_defines.svh.
`timescale 1ns / 1ps
`include "bcd_clock_with_keypad_set_top_defines.svh"

module bcdclk_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [bcdclk_pkg::InDataW-1:0]    s_axis_tdata_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [bcdclk_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import bcdclk_pkg::*;

  logic in_acc, out_stall, digits_ok;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign digits_ok = (m_axis_tdata_o[3:0] < HourTensLimit) &&
                     (m_axis_tdata_o[11:8] < SexLimit) &&
                     (m_axis_tdata_o[19:16] < SexLimit) &&
                     (m_axis_tdata_o[27:25] <= LastPos);

  // every accepted word yields a result next cycle
  `BCDC_ASSERT(a_in_gives_out, clk_i, rst_ni, in_acc |=> m_axis_tvalid_o)
  // a stalled result holds
  `BCDC_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> $stable(m_axis_tdata_o))
  // shown tens digits and position stay in range
  `BCDC_ASSERT(a_out_range, clk_i, rst_ni, m_axis_tvalid_o |-> digits_ok)
  // an empty output register never blocks the input
  `BCDC_ASSERT_ALWAYS(a_ready_when_empty, clk_i, !m_axis_tvalid_o |-> s_axis_tready_o)

  // input payload is not checked beyond the handshake
  logic unused_in;
  assign unused_in = ^s_axis_tdata_i;

endmodule

bind bcd_clock_with_keypad_set_top bcdclk_checker u_bcdclk_checker (.*);
